FILE: sv/gdr_pkg.sv
// Package for the grid ray caster: shared constants, sequencer states and
// the command and result records of the shared divider.
// No dependencies.
package gdr_pkg;

   // Map and screen geometry
   localparam int MAP_W_MAX   = 64;
   localparam int MAP_H_MAX   = 64;
   localparam int VIEW_H      = 120;
   localparam int TILE_ID_MAX = 15;
   localparam int PLATFORM_ID = 9;

   // Tile store
   localparam int TILE_AW    = 12;
   localparam int TILE_DEPTH = 4096;
   localparam int TILE_W     = 8;

   // Arithmetic widths
   localparam int SIDE_W  = 41;   // side distance accumulator
   localparam int DELTA_W = 33;   // 2^32 / |dir|
   localparam int CELL_W  = 10;   // signed grid cell
   localparam int ACC_W   = 49;   // shift-add product
   localparam int ROW_W   = 24;   // signed screen row
   localparam int DIV_NW  = 44;   // divider numerator and quotient
   localparam int DIV_DW  = 24;   // divider denominator
   localparam int DIV_CW  = 6;    // divider bit counter

   localparam logic [23:0] DIST_MIN = 24'd66;
   localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
   localparam logic [16:0] ONE_Q16  = 17'h10000;

   // Configuration register indexes
   localparam logic [2:0] CSR_MAP_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_MAP_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_BLOCK_MASK  = 3'd2;
   localparam logic [2:0] CSR_CAMERA_Z    = 3'd3;
   localparam logic [2:0] CSR_HORIZON_Y   = 3'd4;
   localparam logic [2:0] CSR_WALL_TOP_Z  = 3'd5;
   localparam logic [2:0] CSR_PLAT_BOT_Z  = 3'd6;
   localparam logic [2:0] CSR_PLAT_TOP_Z  = 3'd7;

   // Request kinds
   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_CAST  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_MUL,
      ST_STEP,
      ST_CHECK,
      ST_PERP,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      DS_X,
      DS_Y,
      DS_TOP,
      DS_BOT
   } div_sel_type;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] num;
      logic [DIV_DW-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [DIV_NW-1:0] quo;
   } div_res_type;

endpackage

FILE: sv/gdr_if.sv
// Request and response channel interfaces of the grid ray caster.
// Depends on nothing; widths follow the request and response fields.
interface gdr_req_if;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [11:0]         tile_index;
   logic [7:0]          tile_value;
   logic [21:0]         eye_x;
   logic [21:0]         eye_y;
   logic signed [18:0]  ray_dx;
   logic signed [18:0]  ray_dy;

   modport source (output valid, kind, tile_index, tile_value, eye_x, eye_y,
                   ray_dx, ray_dy, input ready);
   modport sink (input valid, kind, tile_index, tile_value, eye_x, eye_y,
                 ray_dx, ray_dy, output ready);
endinterface

interface gdr_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [3:0]  hit_tile_id;
   logic        hit_side;
   logic [23:0] distance;
   logic [6:0]  span_top;
   logic [6:0]  span_bottom;
   logic        span_valid;

   modport source (output valid, hit, hit_tile_id, hit_side, distance,
                   span_top, span_bottom, span_valid, input ready);
   modport sink (input valid, hit, hit_tile_id, hit_side, distance,
                 span_top, span_bottom, span_valid, output ready);
endinterface

FILE: sv/grid_dda_ray_wall_cast.sv
// Top level of the grid ray caster: tile store, DDA walk sequencer and span math.
// Depends on gdr_pkg, the channel interfaces in gdr_if and the divider gdr_div.
//
//  channel   direction  carries
//  req_chan  in         store: tile_index, tile_value; cast: eye_x/y, ray_dx/dy
//  rsp_chan  out        hit, hit_tile_id, hit_side, distance, span fields
//  csr_*     in         write enable, 3-bit register index, 25-bit data
//
// A store request writes the tile memory. A cast runs the shared divider for the two
// inverse deltas and, after a hit, the two span rows, a shift-add for the first
// side distances and a tile memory read for each grid step. The block takes no
// request while a cast runs. Reset is synchronous; the tile memory is not cleared.
// A finished response waits in the output register; the block only stalls
// when a new cast finishes before the previous response was taken.
module grid_dda_ray_wall_cast (
   input  logic        clock,
   input  logic        reset,
   gdr_req_if.sink     req_chan,
   gdr_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [24:0] csr_wdata
);

   // Configuration registers
   logic [6:0]         map_width_ff;
   logic [6:0]         map_height_ff;
   logic [15:0]        block_mask_ff;
   logic [19:0]        camera_z_ff;
   logic signed [24:0] horizon_y_ff;
   logic [17:0]        wall_top_z_ff;
   logic [17:0]        plat_bot_z_ff;
   logic [17:0]        plat_top_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= 7'd64;
         map_height_ff <= 7'd64;
         block_mask_ff <= 16'd65534;
         camera_z_ff   <= 20'd32768;
         horizon_y_ff  <= 25'sd3932160;
         wall_top_z_ff <= 18'd65536;
         plat_bot_z_ff <= 18'd0;
         plat_top_z_ff <= 18'd65536;
      end else if (csr_we) begin
         case (csr_addr)
            gdr_pkg::CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata[6:0];
            gdr_pkg::CSR_MAP_HEIGHT: map_height_ff <= csr_wdata[6:0];
            gdr_pkg::CSR_BLOCK_MASK: block_mask_ff <= csr_wdata[15:0];
            gdr_pkg::CSR_CAMERA_Z:   camera_z_ff   <= csr_wdata[19:0];
            gdr_pkg::CSR_HORIZON_Y:  horizon_y_ff  <= $signed(csr_wdata);
            gdr_pkg::CSR_WALL_TOP_Z: wall_top_z_ff <= csr_wdata[17:0];
            gdr_pkg::CSR_PLAT_BOT_Z: plat_bot_z_ff <= csr_wdata[17:0];
            gdr_pkg::CSR_PLAT_TOP_Z: plat_top_z_ff <= csr_wdata[17:0];
            default: ;
         endcase
      end
   end

   // Map size in use, saturated at the largest map.
   logic [6:0] map_w;
   logic [6:0] map_h;
   logic [7:0] step_limit;

   always_comb begin
      map_w = (map_width_ff > 7'(gdr_pkg::MAP_W_MAX)) ? 7'(gdr_pkg::MAP_W_MAX) : map_width_ff;
      map_h = (map_height_ff > 7'(gdr_pkg::MAP_H_MAX)) ?
              7'(gdr_pkg::MAP_H_MAX) : map_height_ff;
      step_limit = 8'(map_w) + 8'(map_h) + 8'd8;
   end

   // Sequencer state and per-cast registers
   gdr_pkg::state_type   state_ff, state_in;
   gdr_pkg::div_sel_type sel_ff;

   logic signed [gdr_pkg::CELL_W-1:0] ax_cell_ff, ay_cell_ff;
   logic                              ax_neg_ff, ay_neg_ff;
   logic                              ax_inf_ff, ay_inf_ff;
   logic [16:0]                       ax_dist_ff, ay_dist_ff;
   logic [18:0]                       ax_mag_ff, ay_mag_ff;
   logic [gdr_pkg::DELTA_W-1:0]       ax_delta_ff, ay_delta_ff;
   logic [gdr_pkg::SIDE_W-1:0]        ax_side_ff, ay_side_ff;
   logic [gdr_pkg::ACC_W-1:0]         acc_ff;
   logic [4:0]                        mul_cnt_ff;
   logic                              mul_y_ff;
   logic [7:0]                        step_cnt_ff;
   logic                              hit_ff;
   logic                              side_ff;
   logic [3:0]                        tile_ff;
   logic [23:0]                       dist_ff;
   logic signed [gdr_pkg::ROW_W-1:0]  row_top_ff;

   // Tile memory
   logic [gdr_pkg::TILE_W-1:0]  tile_mem [gdr_pkg::TILE_DEPTH];
   logic [gdr_pkg::TILE_W-1:0]  rd_data_ff;
   logic [gdr_pkg::TILE_AW-1:0] rd_addr;

   // Handshake and divider hookup
   logic                 req_acc;
   logic                 rsp_free;
   logic                 div_start;
   logic                 rd_en;
   gdr_pkg::div_cmd_type div_cmd;
   gdr_pkg::div_res_type div_res;

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_chan.valid || rsp_chan.ready;

   gdr_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   // One DDA step: pick the nearer boundary and advance that axis.
   logic                              adv_x;
   logic signed [gdr_pkg::CELL_W-1:0] ax_cell_n, ay_cell_n;
   logic [gdr_pkg::SIDE_W-1:0]        ax_side_n, ay_side_n;
   logic                              off_map;
   logic [12:0]                       row_base;

   always_comb begin
      if (ax_inf_ff != ay_inf_ff) begin
         adv_x = !ax_inf_ff;
      end else begin
         adv_x = (ax_side_ff < ay_side_ff);
      end
      ax_cell_n = ax_cell_ff;
      ay_cell_n = ay_cell_ff;
      ax_side_n = ax_side_ff;
      ay_side_n = ay_side_ff;
      if (adv_x) begin
         ax_cell_n = ax_cell_ff + (ax_neg_ff ? -10'sd1 : 10'sd1);
         ax_side_n = ax_side_ff + (ax_inf_ff ? gdr_pkg::SIDE_W'(gdr_pkg::ONE_Q16) :
                                               gdr_pkg::SIDE_W'(ax_delta_ff));
      end else begin
         ay_cell_n = ay_cell_ff + (ay_neg_ff ? -10'sd1 : 10'sd1);
         ay_side_n = ay_side_ff + (ay_inf_ff ? gdr_pkg::SIDE_W'(gdr_pkg::ONE_Q16) :
                                               gdr_pkg::SIDE_W'(ay_delta_ff));
      end
      off_map = (ax_cell_n < 10'sd0) || (ay_cell_n < 10'sd0) ||
                (ax_cell_n >= $signed({3'b000, map_w})) ||
                (ay_cell_n >= $signed({3'b000, map_h}));
      row_base = 13'(ay_cell_n[5:0]) * 13'(map_w);
      rd_addr  = gdr_pkg::TILE_AW'(row_base + 13'(ax_cell_n[5:0]));
   end

   // Tile test after the memory read
   logic [3:0] rd_tile;
   logic       blocking;

   always_comb begin
      rd_tile  = rd_data_ff[3:0];
      blocking = (rd_tile != 4'd0) && block_mask_ff[rd_tile];
   end

   // Shift-add product for the first side distance of one axis.
   logic [16:0]                 mul_dist;
   logic [gdr_pkg::DELTA_W-1:0] mul_delta;
   logic [gdr_pkg::ACC_W-1:0]   acc_n;
   logic [gdr_pkg::SIDE_W-1:0]  side_init;

   always_comb begin
      mul_dist  = mul_y_ff ? ay_dist_ff : ax_dist_ff;
      mul_delta = mul_y_ff ? ay_delta_ff : ax_delta_ff;
      acc_n     = {acc_ff[gdr_pkg::ACC_W-2:0], 1'b0} +
                  (mul_dist[mul_cnt_ff] ? gdr_pkg::ACC_W'(mul_delta) : '0);
      side_init = gdr_pkg::SIDE_W'(acc_n[gdr_pkg::ACC_W-1:16]);
   end

   // Perpendicular distance at the hit, clamped to the output range.
   logic [gdr_pkg::SIDE_W-1:0] perp;
   logic                       perp_inf;
   logic [23:0]                dist_n;

   always_comb begin
      if (side_ff) begin
         perp     = ay_side_ff - gdr_pkg::SIDE_W'(ay_delta_ff);
         perp_inf = ay_inf_ff;
      end else begin
         perp     = ax_side_ff - gdr_pkg::SIDE_W'(ax_delta_ff);
         perp_inf = ax_inf_ff;
      end
      if (perp_inf || (perp > gdr_pkg::SIDE_W'(gdr_pkg::DIST_MAX))) begin
         dist_n = gdr_pkg::DIST_MAX;
      end else if (perp < gdr_pkg::SIDE_W'(gdr_pkg::DIST_MIN)) begin
         dist_n = gdr_pkg::DIST_MIN;
      end else begin
         dist_n = perp[23:0];
      end
   end

   // Height difference from the eye for the span edge being divided.
   logic [17:0]        z_sel;
   logic signed [20:0] z_diff;
   logic               z_neg;
   logic [19:0]        z_mag;
   logic [26:0]        z_scaled;

   always_comb begin
      if (sel_ff == gdr_pkg::DS_BOT) begin
         z_sel = (tile_ff == 4'(gdr_pkg::PLATFORM_ID)) ? plat_bot_z_ff : 18'd0;
      end else begin
         z_sel = (tile_ff == 4'(gdr_pkg::PLATFORM_ID)) ? plat_top_z_ff : wall_top_z_ff;
      end
      z_diff   = $signed({1'b0, camera_z_ff}) - $signed({3'b000, z_sel});
      z_neg    = z_diff[20];
      z_mag    = z_neg ? 20'(-z_diff) : z_diff[19:0];
      z_scaled = 27'(z_mag) * 27'(gdr_pkg::VIEW_H);
   end

   // Divider operands for the current division.
   always_comb begin
      div_cmd.start = div_start;
      case (sel_ff)
         gdr_pkg::DS_X: begin
            div_cmd.num = gdr_pkg::DIV_NW'(1) << 32;
            div_cmd.den = gdr_pkg::DIV_DW'(ax_mag_ff);
         end
         gdr_pkg::DS_Y: begin
            div_cmd.num = gdr_pkg::DIV_NW'(1) << 32;
            div_cmd.den = gdr_pkg::DIV_DW'(ay_mag_ff);
         end
         default: begin
            div_cmd.num = {1'b0, z_scaled, 16'h0000};
            div_cmd.den = dist_ff;
         end
      endcase
   end

   // Screen row from a quotient: horizon plus signed offset, truncated toward zero.
   logic signed [39:0]               off;
   logic signed [39:0]               row_sum;
   logic signed [gdr_pkg::ROW_W-1:0] row_n;

   always_comb begin
      off     = z_neg ? -$signed({2'b00, div_res.quo[37:0]}) :
                        $signed({2'b00, div_res.quo[37:0]});
      row_sum = 40'(horizon_y_ff) + off;
      row_n   = row_sum[39:16] +
                ((row_sum[39] && (row_sum[15:0] != 16'h0000)) ? 24'sd1 : 24'sd0);
   end

   // Top row of the span, clamped to the top of the screen.
   logic signed [gdr_pkg::ROW_W-1:0] top_c;

   always_comb begin
      top_c = (row_top_ff < 24'sd0) ? 24'sd0 : row_top_ff;
   end

   // Bottom row is only needed at the last division; keep it for the response.
   logic signed [gdr_pkg::ROW_W-1:0] row_bot_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gdr_pkg::ST_IDLE: begin
            if (req_acc && (req_chan.kind == gdr_pkg::KIND_CAST)) begin
               state_in = gdr_pkg::ST_DIV_GO;
            end
         end
         gdr_pkg::ST_DIV_GO:   state_in = gdr_pkg::ST_DIV_WAIT;
         gdr_pkg::ST_DIV_WAIT: begin
            if (div_res.done) begin
               case (sel_ff)
                  gdr_pkg::DS_Y:   state_in = gdr_pkg::ST_MUL;
                  gdr_pkg::DS_BOT: state_in = gdr_pkg::ST_FIN;
                  default:         state_in = gdr_pkg::ST_DIV_GO;
               endcase
            end
         end
         gdr_pkg::ST_MUL: begin
            if ((mul_cnt_ff == 5'd0) && mul_y_ff) begin
               state_in = gdr_pkg::ST_STEP;
            end
         end
         gdr_pkg::ST_STEP: state_in = off_map ? gdr_pkg::ST_PERP : gdr_pkg::ST_CHECK;
         gdr_pkg::ST_CHECK: begin
            if (blocking) begin
               state_in = gdr_pkg::ST_PERP;
            end else if ((step_cnt_ff + 8'd1) == step_limit) begin
               state_in = gdr_pkg::ST_FIN;
            end else begin
               state_in = gdr_pkg::ST_STEP;
            end
         end
         gdr_pkg::ST_PERP: state_in = gdr_pkg::ST_DIV_GO;
         gdr_pkg::ST_FIN: begin
            if (rsp_free) begin
               state_in = gdr_pkg::ST_IDLE;
            end
         end
         default: state_in = gdr_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_chan.ready = (state_ff == gdr_pkg::ST_IDLE);
      div_start      = (state_ff == gdr_pkg::ST_DIV_GO);
      rd_en          = (state_ff == gdr_pkg::ST_STEP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gdr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Tile memory: store requests write, the walk reads one tile per step.
   always_ff @(posedge clock) begin
      if (req_acc && (req_chan.kind == gdr_pkg::KIND_STORE)) begin
         tile_mem[req_chan.tile_index] <= req_chan.tile_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tile_mem[rd_addr];
      end
   end

   // Cast datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= gdr_pkg::DS_X;
      end else begin
         case (state_ff)
            gdr_pkg::ST_IDLE: begin
               if (req_acc) begin
                  sel_ff <= gdr_pkg::DS_X;
               end
            end
            gdr_pkg::ST_DIV_WAIT: begin
               if (div_res.done) begin
                  case (sel_ff)
                     gdr_pkg::DS_X:   sel_ff <= gdr_pkg::DS_Y;
                     gdr_pkg::DS_TOP: sel_ff <= gdr_pkg::DS_BOT;
                     default:         sel_ff <= sel_ff;
                  endcase
               end
            end
            gdr_pkg::ST_PERP: sel_ff <= gdr_pkg::DS_TOP;
            default: sel_ff <= sel_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         gdr_pkg::ST_IDLE: begin
            // Split the eye position into cell and distance to the first boundary.
            ax_cell_ff  <= gdr_pkg::CELL_W'(req_chan.eye_x[21:16]);
            ay_cell_ff  <= gdr_pkg::CELL_W'(req_chan.eye_y[21:16]);
            ax_neg_ff   <= req_chan.ray_dx[18];
            ay_neg_ff   <= req_chan.ray_dy[18];
            ax_inf_ff   <= (req_chan.ray_dx == 19'sd0);
            ay_inf_ff   <= (req_chan.ray_dy == 19'sd0);
            ax_dist_ff  <= req_chan.ray_dx[18] ? {1'b0, req_chan.eye_x[15:0]} :
                           gdr_pkg::ONE_Q16 - {1'b0, req_chan.eye_x[15:0]};
            ay_dist_ff  <= req_chan.ray_dy[18] ? {1'b0, req_chan.eye_y[15:0]} :
                           gdr_pkg::ONE_Q16 - {1'b0, req_chan.eye_y[15:0]};
            ax_mag_ff   <= req_chan.ray_dx[18] ? 19'(-req_chan.ray_dx) : 19'(req_chan.ray_dx);
            ay_mag_ff   <= req_chan.ray_dy[18] ? 19'(-req_chan.ray_dy) : 19'(req_chan.ray_dy);
            step_cnt_ff <= 8'd0;
            hit_ff      <= 1'b0;
            side_ff     <= 1'b0;
            tile_ff     <= 4'd0;
         end
         gdr_pkg::ST_DIV_WAIT: begin
            if (div_res.done) begin
               case (sel_ff)
                  gdr_pkg::DS_X: begin
                     ax_delta_ff <= ax_inf_ff ? '0 : div_res.quo[gdr_pkg::DELTA_W-1:0];
                  end
                  gdr_pkg::DS_Y: begin
                     ay_delta_ff <= ay_inf_ff ? '0 : div_res.quo[gdr_pkg::DELTA_W-1:0];
                     acc_ff      <= '0;
                     mul_cnt_ff  <= 5'd16;
                     mul_y_ff    <= 1'b0;
                  end
                  gdr_pkg::DS_TOP: row_top_ff <= row_n;
                  default:         row_bot_ff <= row_n;
               endcase
            end
         end
         gdr_pkg::ST_MUL: begin
            if (mul_cnt_ff == 5'd0) begin
               if (mul_y_ff) begin
                  ay_side_ff <= ay_inf_ff ? gdr_pkg::SIDE_W'(ay_dist_ff) : side_init;
               end else begin
                  ax_side_ff <= ax_inf_ff ? gdr_pkg::SIDE_W'(ax_dist_ff) : side_init;
               end
               acc_ff     <= '0;
               mul_cnt_ff <= 5'd16;
               mul_y_ff   <= 1'b1;
            end else begin
               acc_ff     <= acc_n;
               mul_cnt_ff <= mul_cnt_ff - 5'd1;
            end
         end
         gdr_pkg::ST_STEP: begin
            ax_cell_ff <= ax_cell_n;
            ay_cell_ff <= ay_cell_n;
            ax_side_ff <= ax_side_n;
            ay_side_ff <= ay_side_n;
            side_ff    <= !adv_x;
            if (off_map) begin
               hit_ff  <= 1'b1;
               tile_ff <= 4'd1;
            end
         end
         gdr_pkg::ST_CHECK: begin
            step_cnt_ff <= step_cnt_ff + 8'd1;
            if (blocking) begin
               hit_ff  <= 1'b1;
               tile_ff <= rd_tile;
            end
         end
         gdr_pkg::ST_PERP: dist_ff <= dist_n;
         default: ;
      endcase
   end

   // Response register
   logic        rsp_valid_ff;
   logic        rsp_hit_ff;
   logic [3:0]  rsp_tile_ff;
   logic        rsp_side_ff;
   logic [23:0] rsp_dist_ff;
   logic [6:0]  rsp_top_ff;
   logic [6:0]  rsp_bot_ff;
   logic        rsp_span_ff;
   logic        fin_go;
   logic signed [gdr_pkg::ROW_W-1:0] bot_fin;

   assign fin_go  = (state_ff == gdr_pkg::ST_FIN) && rsp_free;
   assign bot_fin = (row_bot_ff >= 24'(gdr_pkg::VIEW_H)) ? 24'(gdr_pkg::VIEW_H - 1) : row_bot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_hit_ff  <= hit_ff;
         rsp_tile_ff <= hit_ff ? tile_ff : 4'd0;
         rsp_side_ff <= hit_ff && side_ff;
         rsp_dist_ff <= hit_ff ? dist_ff : 24'd0;
         if (hit_ff && (bot_fin > top_c)) begin
            rsp_top_ff  <= top_c[6:0];
            rsp_bot_ff  <= bot_fin[6:0];
            rsp_span_ff <= 1'b1;
         end else begin
            rsp_top_ff  <= 7'd0;
            rsp_bot_ff  <= 7'd0;
            rsp_span_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.hit_tile_id = rsp_tile_ff;
   assign rsp_chan.hit_side    = rsp_side_ff;
   assign rsp_chan.distance    = rsp_dist_ff;
   assign rsp_chan.span_top    = rsp_top_ff;
   assign rsp_chan.span_bottom = rsp_bot_ff;
   assign rsp_chan.span_valid  = rsp_span_ff;

endmodule

FILE: sv/gdr_div.sv
// Shared restoring divider of the grid ray caster, one quotient bit a cycle.
// Depends on gdr_pkg for widths and the command and result records.
module gdr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  gdr_pkg::div_cmd_type cmd,
   output gdr_pkg::div_res_type res
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [gdr_pkg::DIV_CW-1:0] cnt_ff, cnt_in;
   logic [gdr_pkg::DIV_NW-1:0] num_ff, num_in;
   logic [gdr_pkg::DIV_NW-1:0] quo_ff, quo_in;
   logic [gdr_pkg::DIV_DW-1:0] rem_ff, rem_in;
   logic [gdr_pkg::DIV_DW-1:0] den_ff, den_in;
   logic [gdr_pkg::DIV_DW:0]   trial;
   logic [gdr_pkg::DIV_DW:0]   diff;
   logic                       qbit;

   // One restoring step: shift in the next numerator bit and try a subtract.
   always_comb begin
      trial = {rem_ff, num_ff[gdr_pkg::DIV_NW-1]};
      diff  = trial - {1'b0, den_ff};
      qbit  = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = cmd.num;
         rem_in  = '0;
         den_in  = cmd.den;
      end else if (busy_ff) begin
         num_in = {num_ff[gdr_pkg::DIV_NW-2:0], 1'b0};
         quo_in = {quo_ff[gdr_pkg::DIV_NW-2:0], qbit};
         rem_in = qbit ? diff[gdr_pkg::DIV_DW-1:0] : trial[gdr_pkg::DIV_DW-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == gdr_pkg::DIV_CW'(gdr_pkg::DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign res.done = done_ff;
   assign res.quo  = quo_ff;

endmodule

FILE: sv/gdr_checker.sv
// Port-level checks for the grid ray caster and the bind that attaches them.
// Depends on gdr_pkg and the top level grid_dda_ray_wall_cast.
module gdr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [3:0]  rsp_tile,
   input logic        rsp_side,
   input logic [23:0] rsp_dist,
   input logic [6:0]  rsp_top,
   input logic [6:0]  rsp_bot,
   input logic        rsp_span
);

   // A pending response stays up until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A ray that finds nothing reports all fields as zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> (rsp_tile == 4'd0) && !rsp_side &&
      (rsp_dist == 24'd0) && (rsp_top == 7'd0) && (rsp_bot == 7'd0) && !rsp_span)
      else $error("miss response carries nonzero fields");

   // A valid span lies on screen with its bottom below its top.
   a_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span |-> rsp_hit && (rsp_bot > rsp_top) &&
      (rsp_bot <= 7'(gdr_pkg::VIEW_H - 1)))
      else $error("span out of range");

   // Hit distance respects the lower clamp.
   a_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> (rsp_dist >= gdr_pkg::DIST_MIN))
      else $error("hit distance below minimum");

   // A cast keeps the block busy for the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == gdr_pkg::KIND_CAST) |=> !req_ready)
      else $error("request taken during a cast");

endmodule

bind grid_dda_ray_wall_cast gdr_checker u_gdr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_kind  (req_chan.kind),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hit   (rsp_chan.hit),
   .rsp_tile  (rsp_chan.hit_tile_id),
   .rsp_side  (rsp_chan.hit_side),
   .rsp_dist  (rsp_chan.distance),
   .rsp_top   (rsp_chan.span_top),
   .rsp_bot   (rsp_chan.span_bottom),
   .rsp_span  (rsp_chan.span_valid)
);

FILE: dv/tb_top.sv
// Self-checking testbench for grid_dda_ray_wall_cast: tile stores and ray casts
// are checked against an in-bench DDA predictor, under random idling and stalls.
// Depends on gdr_pkg, the channel interfaces in gdr_if and the block itself.
`timescale 1ns / 100ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 3000;
   localparam int SETTLE_CYCLES  = 600;
   // Maps in use never span more tiles than the filled part of the store.
   localparam int FILL_TILES     = 1024;

   // Expected response record
   typedef struct {
      logic        hit;
      logic [3:0]  tile_id;
      logic        side;
      logic [23:0] distance;
      logic [6:0]  top;
      logic [6:0]  bottom;
      logic        span_ok;
   } wall_hit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = gdr_pkg::CSR_MAP_WIDTH;
   logic [24:0] csr_wdata = '0;

   gdr_req_if req_chan ();
   gdr_rsp_if rsp_chan ();

   grid_dda_ray_wall_cast uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the tile map and the registers.
   logic [7:0]         tile_shadow [gdr_pkg::TILE_DEPTH];
   logic [6:0]         cfg_width;
   logic [6:0]         cfg_height;
   logic [15:0]        cfg_mask;
   logic [19:0]        cfg_cam_z;
   logic signed [24:0] cfg_horizon;
   logic [17:0]        cfg_wall_z;
   logic [17:0]        cfg_plat_bot;
   logic [17:0]        cfg_plat_top;

   wall_hit_type expected_hits [$];
   int  mismatches = 0;
   int  casts_sent = 0;
   int  stores_sent = 0;
   int  hits_checked = 0;
   bit  sender_idles = 1'b1;
   bit  receiver_idles = 1'b1;
   bit  hold_request = 1'b0;
   int  quiet_cycles = 0;

   always #10 clock = ~clock;

   // Screen row of a height difference seen at a given distance.
   function automatic int span_row(longint z_diff, longint dist_q);
      longint off;
      off = (z_diff * gdr_pkg::VIEW_H * 65536) / dist_q;
      return int'((longint'(cfg_horizon) + off) / 65536);
   endfunction

   // DDA walk through the shadow map for one cast.
   function automatic wall_hit_type predict_wall_hit(logic [21:0] ex, logic [21:0] ey,
                                                     logic signed [18:0] dx,
                                                     logic signed [18:0] dy);
      wall_hit_type r;
      longint side_d [2];
      longint delta [2];
      int     cell_pos [2];
      int     dirn [2];
      bit     inf [2];
      longint pos, mag, frac, bnd_d, perp;
      int     w, h, a, sd, top, bot;
      logic [3:0] tile;
      logic [31:0] z0, z1;
      bit     found;
      r = '{default: '0};
      w = (cfg_width > gdr_pkg::MAP_W_MAX) ? gdr_pkg::MAP_W_MAX : int'(cfg_width);
      h = (cfg_height > gdr_pkg::MAP_H_MAX) ? gdr_pkg::MAP_H_MAX : int'(cfg_height);
      for (int i = 0; i < 2; i++) begin
         pos = (i == 0) ? longint'(ex) : longint'(ey);
         mag = (i == 0) ? longint'(dx) : longint'(dy);
         frac = pos & 16'hFFFF;
         cell_pos[i] = int'(pos >> 16);
         inf[i] = (mag == 0);
         dirn[i] = (mag < 0) ? -1 : 1;
         if (mag < 0) mag = -mag;
         delta[i] = inf[i] ? 0 : (longint'(1) << 32) / mag;
         bnd_d = (dirn[i] < 0) ? frac : 65536 - frac;
         side_d[i] = inf[i] ? bnd_d : (bnd_d * delta[i]) >> 16;
      end
      found = 1'b0;
      sd = 0;
      tile = '0;
      for (int s = 0; s < w + h + 8; s++) begin
         if (inf[0] != inf[1]) a = inf[0] ? 1 : 0;
         else a = (side_d[0] < side_d[1]) ? 0 : 1;
         side_d[a] += inf[a] ? 65536 : delta[a];
         cell_pos[a] += dirn[a];
         sd = a;
         if (cell_pos[0] < 0 || cell_pos[1] < 0 || cell_pos[0] >= w || cell_pos[1] >= h) begin
            tile = 4'd1;
            found = 1'b1;
            break;
         end
         tile = tile_shadow[(cell_pos[1] * w + cell_pos[0]) &
                            (gdr_pkg::TILE_DEPTH - 1)][3:0];
         if (tile != 0 && cfg_mask[tile]) begin
            found = 1'b1;
            break;
         end
      end
      if (!found) return r;
      perp = side_d[sd] - delta[sd];
      if (inf[sd] || perp > longint'(gdr_pkg::DIST_MAX)) perp = longint'(gdr_pkg::DIST_MAX);
      if (perp < longint'(gdr_pkg::DIST_MIN)) perp = longint'(gdr_pkg::DIST_MIN);
      // Platform tiles use their own lower and upper heights.
      if (tile == gdr_pkg::PLATFORM_ID) begin
         z0 = cfg_plat_bot;
         z1 = cfg_plat_top;
      end else begin
         z0 = 0;
         z1 = cfg_wall_z;
      end
      top = span_row(longint'(cfg_cam_z) - longint'(z1), perp);
      bot = span_row(longint'(cfg_cam_z) - longint'(z0), perp);
      if (top < 0) top = 0;
      if (bot >= gdr_pkg::VIEW_H) bot = gdr_pkg::VIEW_H - 1;
      r.hit = 1'b1;
      r.tile_id = tile;
      r.side = sd[0];
      r.distance = perp[23:0];
      if (bot > top) begin
         r.top = top[6:0];
         r.bottom = bot[6:0];
         r.span_ok = 1'b1;
      end
      return r;
   endfunction

   // Send one request; the prediction is made when the block accepts it.
   task automatic send_request(logic kind, logic [11:0] idx, logic [7:0] val,
                               logic [21:0] ex, logic [21:0] ey,
                               logic signed [18:0] dx, logic signed [18:0] dy);
      @(negedge clock);
      while (sender_idles && $urandom_range(99) < 33) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.kind = kind;
      req_chan.tile_index = idx;
      req_chan.tile_value = val;
      req_chan.eye_x = ex;
      req_chan.eye_y = ey;
      req_chan.ray_dx = dx;
      req_chan.ray_dy = dy;
      do @(posedge clock); while (!req_chan.ready);
      if (kind == gdr_pkg::KIND_STORE) begin
         tile_shadow[idx] = val;
         stores_sent++;
      end else begin
         expected_hits.push_back(predict_wall_hit(ex, ey, dx, dy));
         casts_sent++;
      end
   endtask

   task automatic store_tile(int idx, int val);
      send_request(gdr_pkg::KIND_STORE, idx[11:0], val[7:0], '0, '0, '0, '0);
   endtask

   task automatic cast_ray(logic [21:0] ex, logic [21:0] ey,
                           logic signed [18:0] dx, logic signed [18:0] dy);
      send_request(gdr_pkg::KIND_CAST, 12'($urandom_range(4095)), 8'($urandom_range(255)),
                   ex, ey, dx, dy);
   endtask

   // Drop valid and wait until every expected response has come back.
   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [24:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = addr;
      csr_wdata = data;
      case (addr)
         gdr_pkg::CSR_MAP_WIDTH:  cfg_width = data[6:0];
         gdr_pkg::CSR_MAP_HEIGHT: cfg_height = data[6:0];
         gdr_pkg::CSR_BLOCK_MASK: cfg_mask = data[15:0];
         gdr_pkg::CSR_CAMERA_Z:   cfg_cam_z = data[19:0];
         gdr_pkg::CSR_HORIZON_Y:  cfg_horizon = data;
         gdr_pkg::CSR_WALL_TOP_Z: cfg_wall_z = data[17:0];
         gdr_pkg::CSR_PLAT_BOT_Z: cfg_plat_bot = data[17:0];
         gdr_pkg::CSR_PLAT_TOP_Z: cfg_plat_top = data[17:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Write every register in turn; only called with the block idle.
   task automatic load_settings(int w, int h, int mask, int cam, int hor,
                                int wall, int pbot, int ptop);
      drain();
      csr_write(gdr_pkg::CSR_MAP_WIDTH, 25'(w));
      csr_write(gdr_pkg::CSR_MAP_HEIGHT, 25'(h));
      csr_write(gdr_pkg::CSR_BLOCK_MASK, 25'(mask));
      csr_write(gdr_pkg::CSR_CAMERA_Z, 25'(cam));
      csr_write(gdr_pkg::CSR_HORIZON_Y, 25'(hor));
      csr_write(gdr_pkg::CSR_WALL_TOP_Z, 25'(wall));
      csr_write(gdr_pkg::CSR_PLAT_BOT_Z, 25'(pbot));
      csr_write(gdr_pkg::CSR_PLAT_TOP_Z, 25'(ptop));
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // A ray from a random eye: mostly inside the map, sometimes anywhere.
   task automatic random_cast();
      logic [21:0] ex, ey;
      logic signed [18:0] dx, dy;
      int w, h, pick;
      w = (cfg_width > gdr_pkg::MAP_W_MAX) ? gdr_pkg::MAP_W_MAX : int'(cfg_width);
      h = (cfg_height > gdr_pkg::MAP_H_MAX) ? gdr_pkg::MAP_H_MAX : int'(cfg_height);
      if ($urandom_range(9) == 0) begin
         ex = 22'($urandom);
         ey = 22'($urandom);
      end else begin
         ex = {6'($urandom_range(w - 1)), 16'($urandom)};
         ey = {6'($urandom_range(h - 1)), 16'($urandom)};
      end
      pick = $urandom_range(9);
      dx = (pick == 0) ? 19'sd0 : (pick < 3) ? 19'($urandom) : 19'($signed($urandom_range(131072)) - 65536);
      pick = $urandom_range(9);
      dy = (pick == 0) ? 19'sd0 : (pick < 3) ? 19'($urandom) : 19'($signed($urandom_range(131072)) - 65536);
      cast_ray(ex, ey, dx, dy);
   endtask

   // Scatter walls over the map; the id mix covers platforms and ids above 15.
   task automatic random_store();
      int val;
      val = ($urandom_range(3) == 0) ? $urandom_range(255) : 0;
      store_tile($urandom_range(FILL_TILES - 1), val);
   endtask

   task automatic random_mix(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) random_store();
         else random_cast();
      end
   endtask

   // Every tile that a map in use can reach gets written once, so that no
   // cast reads an unwritten entry.
   task automatic test_fill_map();
      sender_idles = 1'b0;
      for (int i = 0; i < FILL_TILES; i++)
         store_tile(i, ($urandom_range(7) == 0) ? $urandom_range(255) : 0);
      sender_idles = 1'b1;
   endtask

   task automatic test_directed();
      load_settings(32, 32, 65534, 32768, 3932160, 65536, 0, 65536);
      store_tile(FILL_TILES - 1, 255);
      store_tile(0, 0);
      store_tile(33 * 1 + 1, gdr_pkg::PLATFORM_ID);
      store_tile(32 * 2 + 5, 0);
      cast_ray({6'd2, 16'h8000}, {6'd2, 16'h8000}, 19'sd65536, 19'sd0);
      cast_ray({6'd2, 16'h8000}, {6'd2, 16'h8000}, 19'sd0, 19'sd0);
      cast_ray({6'd1, 16'h8000}, {6'd1, 16'h8000}, 19'sd0, -19'sd65536);
      cast_ray('0, '0, -19'sd262144, -19'sd262144);
      cast_ray('1, '1, 19'sd262143, 19'sd262143);
      cast_ray({6'd10, 16'h0000}, {6'd10, 16'hFFFF}, 19'sd1, -19'sd1);
      cast_ray({6'd3, 16'h0000}, {6'd3, 16'h0000}, 19'sd65536, 19'sd65536);
      cast_ray({6'd2, 16'h0001}, {6'd1, 16'hFFFF}, -19'sd100, 19'sd262143);
      cast_ray({6'd0, 16'h0000}, {6'd31, 16'hFFFF}, 19'sd0, 19'sd65536);
   endtask

   // Tile zero with bit 0 of the mask set, oversized map sizes and odd heights.
   task automatic test_extreme_settings();
      load_settings(3, 3, 16'hFFFF, 0, -7864320, 262143, 262143, 0);
      store_tile(4, 0);
      store_tile(5, 16);
      random_mix(60);
      load_settings(127, 16, 0, 1048575, 15728640, 0, 0, 262143);
      random_mix(60);
      load_settings(16, 127, 16'h0200, 65536, 0, 131072, 32768, 98304);
      random_mix(60);
   endtask

   task automatic test_random_settings();
      int w, h;
      for (int p = 0; p < 6; p++) begin
         w = $urandom_range(3, 64);
         h = $urandom_range(3, (FILL_TILES / w > 64) ? 64 : FILL_TILES / w);
         load_settings(w, h, $urandom_range(65535),
                       $urandom_range(1048575), $urandom_range(23592960) - 7864320,
                       $urandom_range(262143), $urandom_range(262143),
                       $urandom_range(262143));
         random_mix(80);
      end
      load_settings(32, 32, 65534, 32768, 3932160, 65536, 0, 65536);
   endtask

   // The receiver holds off while requests keep coming, then the sender
   // pauses until the block has nothing left to deliver.
   task automatic test_backpressure();
      hold_request = 1'b1;
      random_mix(30);
      drain();
      random_mix(30);
   endtask

   task automatic test_no_idling();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      random_mix(100);
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // Receiver readiness, with an occasional long hold-off.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_chan.ready = !(receiver_idles && $urandom_range(99) < 33);
      end
   end

   // Response checker.
   always @(posedge clock) begin
      wall_hit_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response with no cast outstanding");
         end else begin
            e = expected_hits.pop_front();
            hits_checked++;
            if (rsp_chan.hit !== e.hit || rsp_chan.hit_tile_id !== e.tile_id ||
                rsp_chan.hit_side !== e.side || rsp_chan.distance !== e.distance ||
                rsp_chan.span_top !== e.top || rsp_chan.span_bottom !== e.bottom ||
                rsp_chan.span_valid !== e.span_ok) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected hit %0d id %0d side %0d dist %0d span %0d..%0d v%0d, got hit %0d id %0d side %0d dist %0d span %0d..%0d v%0d",
                           e.hit, e.tile_id, e.side, e.distance, e.top, e.bottom,
                           e.span_ok, rsp_chan.hit, rsp_chan.hit_tile_id,
                           rsp_chan.hit_side, rsp_chan.distance, rsp_chan.span_top,
                           rsp_chan.span_bottom, rsp_chan.span_valid);
            end
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("grid_dda_ray_wall_cast regression: fail");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.kind = gdr_pkg::KIND_STORE;
      req_chan.tile_index = '0;
      req_chan.tile_value = '0;
      req_chan.eye_x = '0;
      req_chan.eye_y = '0;
      req_chan.ray_dx = '0;
      req_chan.ray_dy = '0;
      cfg_width = 64;
      cfg_height = 64;
      cfg_mask = 65534;
      cfg_cam_z = 32768;
      cfg_horizon = 3932160;
      cfg_wall_z = 65536;
      cfg_plat_bot = 0;
      cfg_plat_top = 65536;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_fill_map();
      test_directed();
      random_mix(100);
      test_extreme_settings();
      test_random_settings();
      test_backpressure();
      test_no_idling();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d tile stores and %0d ray casts, %0d responses checked,",
               stores_sent, casts_sent, hits_checked);
      $display("over extreme and random register settings with stalls on both sides.");
      if (mismatches == 0 && expected_hits.size() == 0)
         $display("grid_dda_ray_wall_cast regression: pass");
      else
         $display("grid_dda_ray_wall_cast regression: fail");
      $finish;
   end

endmodule
